### src/least_loaded_channel_dispatcher_macros.svh
// Assertion helpers for the dispatcher checker.
// Clock i_clk and active-low reset i_rst_n come from the enclosing scope.
`ifndef LEAST_LOADED_CHANNEL_DISPATCHER_MACROS_SVH
`define LEAST_LOADED_CHANNEL_DISPATCHER_MACROS_SVH

// same-cycle implication
`define LLCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("llcd check failed: same-cycle implication");

// next-cycle implication
`define LLCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("llcd check failed: next-cycle implication");

`endif

### src/llcd_pkg.sv
`default_nettype none

package llcd_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 8;

    localparam int ACT_W   = 4;
    localparam int CHAN_W  = 3;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 35;

    localparam int CHUNK_BYTES        = 1048576;
    localparam int CHUNKS_PER_CHANNEL = 4;

    localparam logic [ACT_W-1:0]  ACT_RESET   = ACT_W'(1);
    localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(CHUNKS_PER_CHANNEL * CHUNK_BYTES);

    // action codes
    localparam logic ACTION_ENQUEUE  = 1'b0;
    localparam logic ACTION_COMPLETE = 1'b1;

    // config register indexes
    localparam logic CFG_ACTIVE_CHANNELS = 1'b0;
    localparam logic CFG_BYTE_LIMIT      = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] channel;
        logic [SIZE_W-1:0] size_bytes;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [CHAN_W-1:0]  chosen_channel;
        logic [TOTAL_W-1:0] pending_sum;
        logic [TOTAL_W-1:0] peak_pending;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item, clear accumulators
        logic rd_en;    // read one pending counter
        logic scan;     // read belongs to the selection pass
        logic finish;   // commit updates and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic completion;  // captured item is a completion
        logic fits;        // enqueue passes the global budget
        logic out_free;    // result register can take a new result
    } t_status;

endpackage

`default_nettype wire

### src/least_loaded_channel_dispatcher.sv
// n = active channel count. Each item sweeps counters 0..n-1 for the total; a completion
// or an enqueue over the global budget then loads its result, any other enqueue first
// reduces the pointer and runs the scan pass; a result still held in the result register
// adds its wait. One item at a time: next transfer taken the cycle after the result loads;
// set by the single read port of the counter store, swept again by a fitting enqueue.
// Reset (i_rst_n low, synchronous): counters read as zero via per-entry valid bits,
// pointer and peak cleared, 1 active channel, byte limit 4 MiB; no clearing pass.
`default_nettype none

module least_loaded_channel_dispatcher import llcd_pkg::*; #(
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    // config write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW   = $clog2(MAX_CHANNELS + 1);

    // Controller sequences each item:
    //   sum pass   - reads counters 0..n-1, accumulates the total and n*limit
    //   check      - global budget test for an enqueue; completions go straight to commit
    //   mod        - reduces the rotation pointer below n
    //   scan pass  - reads counters in rotation order, keeps the first minimum that fits
    //   done       - commits counter, pointer and peak when the result register is free
    // The result register decouples the output: a finished result can sit there while
    // the next input transfer is taken and worked on.
    t_cmd            cmd;
    t_status         st;
    logic [NW-1:0]   live_n;
    logic [CH_W-1:0] start_ptr;
    logic [CH_W-1:0] rd_addr;

    llcd_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .i_n        (live_n),
        .i_start    (start_ptr),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    llcd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .o_st        (st),
        .o_n         (live_n),
        .o_start     (start_ptr),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire

### src/llcd_ctrl.sv
`default_nettype none

module llcd_ctrl import llcd_pkg::*; #(
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire t_status                            i_st,
    input  wire logic [$clog2(MAX_CHANNELS+1)-1:0]  i_n,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] i_start,
    output t_cmd                                    o_cmd,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_rd_addr
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW   = $clog2(MAX_CHANNELS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_SUMW  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_SCANW = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [NW-1:0]   r_cnt,   n_cnt;
    logic [CH_W-1:0] r_idx,   n_idx;
    logic            last;

    assign last       = (r_cnt == i_n - NW'(1));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_rd_addr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                // sweep channels 0..n-1 for the total
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_cnt[CH_W-1:0];
                n_cnt       = r_cnt + NW'(1);
                if (last) begin
                    n_state = S_SUMW;
                end
            end
            S_SUMW: begin
                n_idx   = i_start;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_st.completion) begin
                    n_state = S_DONE;
                end else if (i_st.fits) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                // pointer modulo active count, one subtract a cycle
                if (NW'(r_idx) >= i_n) begin
                    n_idx = CH_W'(NW'(r_idx) - i_n);
                end else begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.scan  = 1'b1;
                o_rd_addr   = r_idx;
                n_cnt       = r_cnt + NW'(1);
                if (NW'(r_idx) + NW'(1) == i_n) begin
                    n_idx = '0;
                end else begin
                    n_idx = CH_W'(NW'(r_idx) + NW'(1));
                end
                if (last) begin
                    n_state = S_SCANW;
                end
            end
            S_SCANW: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

### src/llcd_datapath.sv
`default_nettype none

module llcd_datapath import llcd_pkg::*; #(
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire t_in_item                           i_in_data,
    input  wire t_cmd                               i_cmd,
    input  wire logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] i_rd_addr,
    output t_status                                 o_st,
    output logic [$clog2(MAX_CHANNELS+1)-1:0]       o_n,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_start,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output t_out_item                               o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [SIZE_W-1:0]                  i_cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW   = $clog2(MAX_CHANNELS + 1);
    localparam int TW   = SIZE_W + NW;

    // config
    logic [ACT_W-1:0]  r_act;
    logic [SIZE_W-1:0] r_limit;
    logic [NW-1:0]     live_cnt;

    // counter store, valid bit per entry stands in for the reset clear
    logic [SIZE_W-1:0]       r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [SIZE_W-1:0]       r_rd_data;
    logic                    r_rd_vld;
    logic [SIZE_W-1:0]       rd_val;

    logic            r_tag_vld;
    logic            r_tag_scan;
    logic [CH_W-1:0] r_tag_idx;

    logic               r_found;
    logic [CH_W-1:0]    r_best;
    logic [SIZE_W-1:0]  r_best_val;
    logic [CH_W-1:0]    r_start;
    logic [TOTAL_W-1:0] r_peak;
    t_in_item           r_in;
    logic [SIZE_W-1:0]  r_slack;
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_budget;
    logic [SIZE_W-1:0]  r_pend;
    t_out_item          r_out;
    logic               r_out_vld;

    logic               completion;
    logic               chan_ok;
    logic               placed;
    logic [SIZE_W-1:0]  pend_new;
    logic [SIZE_W-1:0]  delta;
    logic [TW-1:0]      sum_placed;
    logic [TOTAL_W-1:0] tot_placed;
    logic [TW-1:0]      budget_left;
    t_out_item          res;
    logic               mem_we;
    logic [CH_W-1:0]    mem_waddr;
    logic [SIZE_W-1:0]  mem_wdata;

    always_comb begin
        if (r_act == '0) begin
            live_cnt = NW'(1);
        end else if (int'(r_act) > MAX_CHANNELS) begin
            live_cnt = NW'(MAX_CHANNELS);
        end else begin
            live_cnt = NW'(r_act);
        end
    end

    assign o_n     = live_cnt;
    assign o_start = r_start;
    assign rd_val  = r_rd_vld ? r_rd_data : '0;

    assign completion  = (r_in.action == ACTION_COMPLETE);
    assign budget_left = (r_budget >= TW'(r_in.size_bytes)) ?
                         (r_budget - TW'(r_in.size_bytes)) : '0;

    assign o_st.completion = completion;
    assign o_st.fits       = (r_total <= budget_left);
    assign o_st.out_free   = !r_out_vld || !i_out_stall;

    // result and commit values
    assign chan_ok    = (int'(r_in.channel) < int'(live_cnt));
    assign placed     = !completion && r_found;
    assign pend_new   = (r_in.size_bytes >= r_pend) ? '0 : (r_pend - r_in.size_bytes);
    assign delta      = r_pend - pend_new;
    assign sum_placed = r_total + TW'(r_in.size_bytes);
    assign tot_placed = TOTAL_W'(sum_placed);

    always_comb begin
        res.peak_pending = r_peak;
        if (completion) begin
            res.accepted       = chan_ok;
            res.chosen_channel = r_in.channel;
            res.pending_sum    = TOTAL_W'(r_total - TW'(delta));
        end else begin
            res.accepted       = placed;
            res.chosen_channel = placed ? CHAN_W'(r_best) : '0;
            res.pending_sum    = placed ? tot_placed : TOTAL_W'(r_total);
            if (placed && (tot_placed > r_peak)) begin
                res.peak_pending = tot_placed;
            end
        end
    end

    assign mem_we    = i_cmd.finish && (completion ? chan_ok : placed);
    assign mem_waddr = completion ? CH_W'(r_in.channel) : r_best;
    assign mem_wdata = completion ? pend_new : (r_best_val + r_in.size_bytes);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= ACT_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_CHANNELS: r_act   <= i_cfg_data[ACT_W-1:0];
                CFG_BYTE_LIMIT:      r_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // counter memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
        r_tag_scan <= i_cmd.scan;
        r_tag_idx  <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_tag_vld <= 1'b0;
            r_start   <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.rd_en;
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_peak    <= res.peak_pending;
                r_out_vld <= 1'b1;
                if (placed) begin
                    if (NW'(r_best) + NW'(1) == live_cnt) begin
                        r_start <= '0;
                    end else begin
                        r_start <= CH_W'(NW'(r_best) + NW'(1));
                    end
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item capture, total sweep and selection pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in     <= i_in_data;
            r_slack  <= (r_limit >= i_in_data.size_bytes) ?
                        (r_limit - i_in_data.size_bytes) : '0;
            r_total  <= '0;
            r_budget <= '0;
            r_pend   <= '0;
            r_found  <= 1'b0;
        end else if (r_tag_vld) begin
            if (!r_tag_scan) begin
                r_total  <= r_total + TW'(rd_val);
                r_budget <= r_budget + TW'(r_limit);
                if (int'(r_tag_idx) == int'(r_in.channel)) begin
                    r_pend <= rd_val;
                end
            end else if ((rd_val <= r_slack) && (!r_found || (rd_val < r_best_val))) begin
                r_best     <= r_tag_idx;
                r_best_val <= rd_val;
                r_found    <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### src/llcd_checker.sv
`default_nettype none

`include "least_loaded_channel_dispatcher_macros.svh"

module llcd_checker import llcd_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // stalled result holds
    `LLCD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_data))

    // one item in flight: busy right after an input transfer
    `LLCD_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

    // a new result only comes out of a busy cycle
    `LLCD_ASSERT_IMPL(a_busy_before_result, $rose(o_out_valid), $past(o_in_stall))

    // peak never falls
    `LLCD_ASSERT_IMPL(a_peak_monotone, o_out_valid && $past(o_out_valid),
                      o_out_data.peak_pending >= $past(o_out_data.peak_pending))

endmodule

bind least_loaded_channel_dispatcher llcd_checker u_llcd_checker (.*);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import llcd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_ACTIVE_CHANNELS;
    logic [31:0] i_cfg_data = '0;

    least_loaded_channel_dispatcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Dispatcher shadow state, updated at each accepted input transfer
    // ---------------------------------------------------------------
    logic [31:0] chan_backlog [8];
    logic [2:0]  scan_origin;
    logic [34:0] backlog_peak;
    logic [3:0]  model_active;
    logic [31:0] model_limit;

    t_out_item   outcomes_due [$];
    int          fail_count = 0;
    bit          in_gaps_on = 1'b1;
    bit          out_gaps_on = 1'b1;
    int          stall_left = 0;
    t_out_item   got_item;
    t_out_item   want_item;

    // zero counts as one channel, anything past eight saturates
    function automatic int unsigned live_channels();
        if (model_active == 4'd0) return 1;
        if (model_active > 4'd8) return 8;
        return 32'(model_active);
    endfunction

    function automatic logic [34:0] backlog_sum(input int unsigned n);
        logic [34:0] sum;
        sum = '0;
        for (int k = 0; k < n; k++) sum += 35'(chan_backlog[k]);
        return sum;
    endfunction

    // Applies one item to the shadow state and queues the result it must produce.
    task automatic dispatch_outcome(input t_in_item it);
        t_out_item       r;
        int unsigned     n, start, k, best;
        longint unsigned sz, cap, room;
        logic [34:0]     sum;
        bit              found;
        n  = live_channels();
        sz = 64'(it.size_bytes);
        r  = '0;
        if (it.action == ACTION_COMPLETE) begin
            r.chosen_channel = it.channel;
            if (it.channel < n) begin
                if (sz >= chan_backlog[it.channel]) chan_backlog[it.channel] = '0;
                else chan_backlog[it.channel] = chan_backlog[it.channel] - it.size_bytes;
                r.accepted = 1'b1;
            end
        end else begin
            // global budget: max(n * limit, size)
            cap = 64'(n);
            cap = cap * 64'(model_limit);
            if (sz > cap) cap = sz;
            if (backlog_sum(n) <= cap - sz) begin
                room = (64'(model_limit) > sz) ? 64'(model_limit) : sz;
                room = room - sz;
                start = scan_origin % n;
                found = 1'b0;
                best = 0;
                for (int s = 0; s < n; s++) begin
                    k = (start + s) % n;
                    if (chan_backlog[k] > room) continue;
                    if (!found || chan_backlog[k] < chan_backlog[best]) begin
                        best = k;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    chan_backlog[best] = chan_backlog[best] + it.size_bytes;
                    scan_origin = 3'((best + 1) % n);
                    sum = backlog_sum(n);
                    if (sum > backlog_peak) backlog_peak = sum;
                    r.accepted = 1'b1;
                    r.chosen_channel = 3'(best);
                end
            end
        end
        r.pending_sum  = backlog_sum(n);
        r.peak_pending = backlog_peak;
        outcomes_due.insert(outcomes_due.size(), r);
    endtask

    // ---------------------------------------------------------------
    // Input side: one transfer per call; valid stays high between
    // back-to-back calls and only drops for a gap or a drain.
    // ---------------------------------------------------------------
    task automatic send_item(input t_in_item it);
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        dispatch_outcome(it);
    endtask

    task automatic enqueue(input logic [31:0] size);
        t_in_item it;
        it.action     = ACTION_ENQUEUE;
        it.channel    = 3'($urandom_range(0, 7));
        it.size_bytes = size;
        send_item(it);
    endtask

    task automatic complete(input logic [2:0] chan, input logic [31:0] size);
        t_in_item it;
        it.action     = ACTION_COMPLETE;
        it.channel    = chan;
        it.size_bytes = size;
        send_item(it);
    endtask

    // drop valid, wait for every outstanding result, leave the block idle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // only called with the block drained
    task automatic write_reg(input logic idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_ACTIVE_CHANNELS) model_active = value[3:0];
        else model_limit = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: compare each transfer, random stall bursts
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got_item = o_out_data;
            if (outcomes_due.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want_item = outcomes_due[0];
                outcomes_due.delete(0);
                if (got_item.accepted !== want_item.accepted) begin
                    $error("accepted: expected %0d, got %0d",
                           want_item.accepted, got_item.accepted);
                    fail_count++;
                end
                if (got_item.chosen_channel !== want_item.chosen_channel) begin
                    $error("chosen_channel: expected %0d, got %0d",
                           want_item.chosen_channel, got_item.chosen_channel);
                    fail_count++;
                end
                if (got_item.pending_sum !== want_item.pending_sum) begin
                    $error("pending_sum: expected %0d, got %0d",
                           want_item.pending_sum, got_item.pending_sum);
                    fail_count++;
                end
                if (got_item.peak_pending !== want_item.peak_pending) begin
                    $error("peak_pending: expected %0d, got %0d",
                           want_item.peak_pending, got_item.peak_pending);
                    fail_count++;
                end
            end
        end
        if (out_gaps_on && stall_left != 0) begin
            stall_left--;
        end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return model_limit;
            9, 10:   return $urandom_range(0, model_limit / 8);
            11:      return model_limit + $urandom_range(1, 16);
            default: return $urandom_range(0, model_limit);
        endcase
    endfunction

    function automatic logic [31:0] random_limit();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return LIMIT_RESET;
            4:       return $urandom;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // Fill and drain spells: enqueue-heavy then completion-heavy, ten items each.
    task automatic random_traffic(input int count);
        logic [2:0]  chan;
        logic [31:0] sent;
        int unsigned enq_pct;
        for (int i = 0; i < count; i++) begin
            enq_pct = ((i / 10) % 2 == 0) ? 75 : 30;
            if ($urandom_range(0, 99) < enq_pct) begin
                enqueue(pick_size());
            end else begin
                if ($urandom_range(0, 4) == 0) chan = 3'($urandom_range(0, 7));
                else chan = 3'($urandom_range(0, live_channels() - 1));
                case ($urandom_range(0, 3))
                    0:       sent = $urandom;
                    1:       sent = chan_backlog[chan];
                    2:       sent = $urandom_range(0, chan_backlog[chan]);
                    default: sent = $urandom_range(0, 64);
                endcase
                complete(chan, sent);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset budget: one channel, 4 MiB. Exact fit, refusal, inactive and
    // saturating completions, oversize payload above the limit.
    task automatic test_reset_budget();
        enqueue(32'd0);
        enqueue(LIMIT_RESET);
        enqueue(32'd1);
        complete(3'd1, 32'd5);
        complete(3'd0, 32'd1);
        complete(3'd0, 32'hFFFF_FFFF);
        enqueue(32'hFFFF_FFFF);
        complete(3'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Zero channels acts as one; fifteen saturates to eight; every channel
    // filled to the 32-bit top gives the largest total and peak.
    task automatic test_channel_count_extremes();
        write_reg(CFG_ACTIVE_CHANNELS, 32'd0);
        write_reg(CFG_BYTE_LIMIT, 32'd1);
        enqueue(32'd1);
        enqueue(32'd1);
        complete(3'd0, 32'd1);
        drain();
        write_reg(CFG_ACTIVE_CHANNELS, 32'd15);
        write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
        repeat (8) enqueue(32'hFFFF_FFFF);
        enqueue(32'd1);
        enqueue(32'd0);
        complete(3'd6, 32'hFFFF_FFFF);
        enqueue(32'd5);
        drain();
    endtask

    // Shrink to three: pointer sits past the active range, counts of the
    // dropped channels are held and come back when re-enabled.
    task automatic test_shrink_and_pointer();
        write_reg(CFG_ACTIVE_CHANNELS, 32'd3);
        enqueue(32'd0);
        complete(3'd5, 32'd7);
        complete(3'd2, 32'hFFFF_FFFF);
        enqueue(32'd100);
        drain();
        write_reg(CFG_ACTIVE_CHANNELS, 32'd8);
        complete(3'd7, 32'hFFFF_FFFF);
        enqueue(32'd3);
        drain();
    endtask

    // Random phases, each under its own setting; the first few are corners.
    task automatic test_random_settings();
        logic [3:0] act;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       write_reg(CFG_BYTE_LIMIT, 32'hFFFF_FFFF);
                1:       write_reg(CFG_BYTE_LIMIT, 32'd1);
                2:       write_reg(CFG_BYTE_LIMIT, 32'd0);
                default: write_reg(CFG_BYTE_LIMIT, random_limit());
            endcase
            case (p)
                0:       act = 4'd8;
                1:       act = 4'd1;
                2:       act = 4'd0;
                3:       act = 4'd15;
                default: act = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 8));
            endcase
            // upper data bits are outside the 4-bit register
            write_reg(CFG_ACTIVE_CHANNELS, {28'($urandom_range(0, 32'h0FFF_FFFF)), act});
            random_traffic(40);
            drain();
        end
    endtask

    // Final stretch: no gaps or stalls on either side.
    task automatic test_back_to_back();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        write_reg(CFG_ACTIVE_CHANNELS, 32'd8);
        write_reg(CFG_BYTE_LIMIT, 32'd2048);
        random_traffic(50);
        drain();
    endtask

    initial begin
        for (int k = 0; k < 8; k++) chan_backlog[k] = '0;
        scan_origin  = '0;
        backlog_peak = '0;
        model_active = ACT_RESET;
        model_limit  = LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_budget();
        test_channel_count_extremes();
        test_shrink_and_pointer();
        test_random_settings();
        test_back_to_back();

        // worst single-item latency at eight channels, with margin
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && outcomes_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
